[src/mhpq_pkg.sv]
package mhpq_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_MODIFY = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] key;
    logic signed [31:0] new_key;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] max_key;
    logic [8:0]         position;
    status_e            status;
    logic [8:0]         occupancy;
  } rsp_t;

endpackage

[src/mhpq_if.sv]
interface mhpq_cmd_if
  import mhpq_pkg::*;
();
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mhpq_rsp_if
  import mhpq_pkg::*;
();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/mhpq_fifo.sv]
module mhpq_fifo
  import mhpq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t out_data_o
);
  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !in_ready_o) else $error("fifo overflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("fifo count out of range");
  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> cnt_q == $past(cnt_q) - 2'd1) else $error("fifo pop count");
`endif
endmodule

[src/mhpq_engine.sv]
module mhpq_engine
  import mhpq_pkg::*;
#(
  parameter int unsigned Capacity = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);
  localparam int unsigned AW = $clog2(Capacity + 1);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned MW = $clog2(Capacity);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UPRD  = 4'd1;
  localparam logic [3:0] S_UPCMP = 4'd2;
  localparam logic [3:0] S_DNRD  = 4'd3;
  localparam logic [3:0] S_DNRD2 = 4'd4;
  localparam logic [3:0] S_DNCMP = 4'd5;
  localparam logic [3:0] S_FRD   = 4'd6;
  localparam logic [3:0] S_FCMP  = 4'd7;
  localparam logic [3:0] S_DLRD  = 4'd8;
  localparam logic [3:0] S_DLWT  = 4'd9;
  localparam logic [3:0] S_RSP   = 4'd10;

  logic [31:0] mem [Capacity];
  logic [31:0] rd_q;
  logic [MW-1:0] ra, wa;
  logic          we;
  logic [31:0]   wd;

  logic [3:0]    st_q, st_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] chd_q, chd_d;
  logic [31:0]   k_q, k_d;
  logic [31:0]   c1_q, c1_d;
  kind_e         kind_q, kind_d;
  rsp_t          rsp_q, rsp_d;
  logic          vld_q, vld_d;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  function automatic logic [31:0] flip(logic [31:0] v);
    return v ^ 32'h8000_0000;
  endfunction

  assign cmd_ready_o = (st_q == S_IDLE) && !vld_q;
  assign rsp_valid_o = vld_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    logic [PW-1:0] par;
    logic [31:0]   big;
    logic [PW-1:0] bigp;
    par   = pos_q >> 1;
    st_d  = st_q;
    cnt_d = cnt_q;
    pos_d = pos_q;
    chd_d = chd_q;
    k_d   = k_q;
    c1_d  = c1_q;
    kind_d = kind_q;
    rsp_d = rsp_q;
    vld_d = vld_q;
    ra = '0;
    wa = '0;
    we = 1'b0;
    wd = k_q;
    big  = rd_q;
    bigp = chd_q + PW'(1);
    if (vld_q && rsp_ready_i) vld_d = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (cmd_valid_i && cmd_ready_o) begin
          kind_d = cmd_i.kind;
          k_d    = flip(cmd_i.key);
          c1_d   = flip(cmd_i.new_key);
          rsp_d  = '0;
          rsp_d.status = ST_OK;
          unique case (cmd_i.kind)
            KIND_INSERT: begin
              if (PW'(cnt_q) >= PW'(Capacity)) begin
                rsp_d.status = ST_FULL;
                st_d = S_RSP;
              end else begin
                cnt_d = cnt_q + AW'(1);
                pos_d = PW'(cnt_q) + PW'(1);
                st_d  = S_UPRD;
              end
            end
            KIND_DELETE: begin
              if (cnt_q == '0) begin
                rsp_d.status = ST_EMPTY;
                st_d = S_RSP;
              end else begin
                ra = MW'(0);
                st_d = S_DLRD;
              end
            end
            default: begin
              pos_d = PW'(1);
              st_d  = S_FRD;
            end
          endcase
        end
      end
      S_DLRD: begin
        rsp_d.max_key = flip(rd_q);
        ra = MW'(cnt_q - AW'(1));
        st_d = S_DLWT;
      end
      S_DLWT: begin
        k_d   = rd_q;
        cnt_d = cnt_q - AW'(1);
        st_d  = S_DNRD;
        pos_d = PW'(1);
        chd_d = PW'(2);
        c1_d  = 32'd0;
        if (cnt_q == AW'(1)) st_d = S_RSP;
      end
      S_UPRD: begin
        if (pos_q <= PW'(1)) begin
          we = 1'b1;
          wa = MW'(pos_q - PW'(1));
          st_d = S_RSP;
        end else begin
          ra = MW'(par - PW'(1));
          st_d = S_UPCMP;
        end
      end
      S_UPCMP: begin
        we = 1'b1;
        wa = MW'(pos_q - PW'(1));
        if (k_q > rd_q) begin
          wd = rd_q;
          pos_d = par;
          st_d = S_UPRD;
        end else begin
          st_d = S_RSP;
        end
      end
      S_DNRD: begin
        if (chd_q > PW'(cnt_q)) begin
          we = 1'b1;
          wa = MW'(pos_q - PW'(1));
          st_d = S_RSP;
        end else begin
          ra = MW'(chd_q - PW'(1));
          st_d = S_DNRD2;
        end
      end
      S_DNRD2: begin
        c1_d = rd_q;
        ra = MW'(chd_q);
        st_d = S_DNCMP;
      end
      S_DNCMP: begin
        big  = c1_q;
        bigp = chd_q;
        if (chd_q < PW'(cnt_q) && c1_q < rd_q) begin
          big  = rd_q;
          bigp = chd_q + PW'(1);
        end
        if (k_q >= big) begin
          we = 1'b1;
          wa = MW'(pos_q - PW'(1));
          st_d = S_RSP;
        end else begin
          we = 1'b1;
          wa = MW'(pos_q - PW'(1));
          wd = big;
          pos_d = bigp;
          chd_d = {bigp[PW-2:0], 1'b0};
          if (bigp[PW-1]) chd_d = '1;
          st_d = S_DNRD;
        end
      end
      S_FRD: begin
        if (pos_q > PW'(cnt_q)) begin
          rsp_d.status = ST_NOT_FOUND;
          st_d = S_RSP;
        end else begin
          ra = MW'(pos_q - PW'(1));
          st_d = S_FCMP;
        end
      end
      S_FCMP: begin
        if (rd_q == k_q) begin
          if (kind_q == KIND_FIND) begin
            rsp_d.position = 9'(pos_q);
            st_d = S_RSP;
          end else begin
            k_d = c1_q;
            chd_d = {pos_q[PW-2:0], 1'b0};
            if (pos_q[PW-1]) chd_d = '1;
            st_d = (c1_q < k_q) ? S_DNRD : S_UPRD;
          end
        end else begin
          pos_d = pos_q + PW'(1);
          st_d = S_FRD;
        end
      end
      S_RSP: begin
        if (!vld_q) begin
          rsp_d.occupancy = 9'(cnt_q);
          vld_d = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      cnt_q <= '0;
      vld_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    chd_q  <= chd_d;
    k_q    <= k_d;
    c1_q   <= c1_d;
    kind_q <= kind_d;
    rsp_q  <= rsp_d;
  end

`ifndef SYNTH
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PW'(cnt_q) <= PW'(Capacity)) else $error("count above capacity");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !rsp_ready_i |=> vld_q && $stable(rsp_q)) else $error("response lost");
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != S_IDLE |-> !cmd_ready_o) else $error("took command while busy");
`endif
endmodule

[src/max_heap_priority_queue_core.sv]
// Binary max-heap of signed 32-bit keys, CAPACITY entries in one single-port
// style memory with registered read. Commands enter a two-beat queue and are
// run one at a time by the engine. Insert and delete walk the tree level by
// level (up to log2(CAPACITY) levels), while find and modify scan the held
// entries linearly. No clearing pass is needed after reset.
module max_heap_priority_queue_core
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input logic          clk_i,
  input logic          rst_ni,
  mhpq_cmd_if.sink     cmd,
  mhpq_rsp_if.source   rsp
);
  logic q_valid, q_ready;
  cmd_t q_data;

  mhpq_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd.valid),
    .in_ready_o  (cmd.ready),
    .in_data_i   (cmd.data),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_data)
  );

  mhpq_engine #(.Capacity(CAPACITY)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_data),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .rsp_o       (rsp.data)
  );
endmodule
